// ----- src/coin_change_way_counter_defines.svh -----
// Assertion macros shared by the checker of the coin change way counter.
// Depends on nothing; include by bare file name.
`ifndef COIN_CHANGE_WAY_COUNTER_DEFINES_SVH
`define COIN_CHANGE_WAY_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ccw_pkg.sv -----
// Shared types and constants of the coin change way counter.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package ccw_pkg;

    // Default values of the top-level parameters
    localparam int MAX_AMOUNT_DEF  = 1023;
    localparam int MAX_COINS_DEF   = 6;
    localparam int COUNT_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int AMOUNT_W  = 10;
    localparam int COIN_W    = 10;
    localparam int NCOIN_W   = 3;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_SLOTS = 6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COIN_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_5 = 3'd6;

    // Reset values of the registers
    localparam logic [NCOIN_W-1:0] COIN_COUNT_RST = 3'd4;
    localparam logic [COIN_W-1:0] COIN_VALUE_RST [NUM_SLOTS] =
        '{10'd2, 10'd5, 10'd3, 10'd6, 10'd1, 10'd1};

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_SETUP = 6'b000100,
        S_RUN   = 6'b001000,
        S_READ  = 6'b010000,
        S_WAIT  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// ----- src/ccw_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
`default_nettype none

module ccw_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register both reads (old data on a same-address write)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ----- src/coin_change_way_counter.sv -----
// Coin change way counter: counts unordered coin combinations per request.
// Depends on ccw_pkg and ccw_ram.
//
// Usage:
//   Input channel (in_valid / in_stall / target_amount) carries one amount
//   per request. Output channel (out_valid / out_stall / way_count,
//   count_overflow) returns one result per request, in order.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   writes coin_count (index 0) and coin_value_0..5 (index 1..6); cfg_ready
//   is always high. Write configuration only while the block is idle.
// Work: the scratch table RAM takes one read-modify-write per cycle, with
//   one pass over the table for clearing and one pass per used coin c
//   with 0 < c <= A, where A is the clamped amount; zero coins and coins
//   larger than A are skipped.
// One request is worked at a time; a new request is taken as soon as the
// previous result sits in the output register, even if it is stalled.
// A stalled result holds its value; the next result waits behind it.
// Reset returns the registers to coin_count 4 and coins 2, 5, 3, 6, 1, 1
// and empties both channels; the table needs no clearing after reset.
`default_nettype none

module coin_change_way_counter #(
    parameter int MAX_AMOUNT  = ccw_pkg::MAX_AMOUNT_DEF,
    parameter int MAX_COINS   = ccw_pkg::MAX_COINS_DEF,
    parameter int COUNT_WIDTH = ccw_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [ccw_pkg::AMOUNT_W-1:0]   target_amount,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [ccw_pkg::OUT_W-1:0]      way_count,
    output logic                                count_overflow,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ccw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ccw_pkg::COIN_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_AMOUNT + 1);
    localparam int CW = (AW > ccw_pkg::AMOUNT_W) ? AW : ccw_pkg::AMOUNT_W;
    localparam int KW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int MW = COUNT_WIDTH + 1;

    // Configuration registers
    logic [ccw_pkg::NCOIN_W-1:0] coin_count_reg, coin_count_next;
    logic [ccw_pkg::COIN_W-1:0]  coin_value_reg [MAX_COINS];
    logic [ccw_pkg::COIN_W-1:0]  coin_value_next [MAX_COINS];

    // Sequencer
    ccw_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   amount_reg, amount_next;
    logic [AW-1:0]   i_reg, i_next;
    logic [AW-1:0]   coin_reg, coin_next;
    logic [ccw_pkg::NCOIN_W-1:0] k_reg, k_next;

    // Update pipeline and forwarding
    logic          p_vld_reg, p_vld_next;
    logic [AW-1:0] p_addr_reg, p_addr_next;
    logic          fwd_a_reg, fwd_a_next;
    logic          fwd_b_reg, fwd_b_next;
    logic [MW-1:0] fwd_data_reg;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    logic [ccw_pkg::OUT_W-1:0]  way_count_reg, way_count_next;
    logic                       count_overflow_reg, count_overflow_next;

    // RAM ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [MW-1:0] wr_data;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic [MW-1:0] rd_data_a, rd_data_b;

    // Datapath
    logic [MW-1:0] word_a, word_b;
    logic [MW-1:0] sum;
    logic [COUNT_WIDTH-1:0] new_cnt;
    logic          new_mark;
    logic [ccw_pkg::NCOIN_W-1:0] n_used;
    logic [KW-1:0] k_idx;
    logic [ccw_pkg::COIN_W-1:0] cur_coin;
    logic [CW-1:0] amt_ext;
    logic [ccw_pkg::CFG_IDX_W-1:0] slot;
    logic          in_accept;
    logic          out_accept;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    // Decode configuration writes; slots beyond MAX_COINS are never used
    always_comb
    begin
        coin_count_next = coin_count_reg;
        for (int j = 0; j < MAX_COINS; j++)
        begin
            coin_value_next[j] = coin_value_reg[j];
        end
        slot = cfg_index - ccw_pkg::REG_COIN_VALUE_0;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ccw_pkg::REG_COIN_COUNT:
                begin
                    coin_count_next = cfg_data[ccw_pkg::NCOIN_W-1:0];
                end
                default:
                begin
                    if (cfg_index <= ccw_pkg::REG_COIN_VALUE_5
                        && 32'(slot) < 32'(MAX_COINS))
                    begin
                        coin_value_next[KW'(slot)] = cfg_data;
                    end
                end
            endcase
        end
    end

    // Clamp coin count and pick the current coin
    assign n_used  = (32'(coin_count_reg) > 32'(MAX_COINS))
                   ? ccw_pkg::NCOIN_W'(MAX_COINS) : coin_count_reg;
    assign k_idx   = (32'(k_reg) < 32'(MAX_COINS)) ? KW'(k_reg) : '0;
    assign cur_coin = coin_value_reg[k_idx];
    assign amt_ext = CW'(target_amount);

    // Forward a write that lands in the same cycle as the read
    assign word_a = fwd_a_reg ? fwd_data_reg : rd_data_a;
    assign word_b = fwd_b_reg ? fwd_data_reg : rd_data_b;

    // Saturating add of two table entries, merge overflow marks
    assign sum = {1'b0, word_a[COUNT_WIDTH-1:0]} + {1'b0, word_b[COUNT_WIDTH-1:0]};
    assign new_cnt  = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
    assign new_mark = word_a[COUNT_WIDTH] | word_b[COUNT_WIDTH] | sum[COUNT_WIDTH];

    // RAM write: clearing pass or pipelined update
    always_comb
    begin
        if (state_reg == ccw_pkg::S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = i_reg;
            wr_data = (i_reg == '0) ? MW'(1) : '0;
        end
        else
        begin
            wr_en   = p_vld_reg;
            wr_addr = p_addr_reg;
            wr_data = {new_mark, new_cnt};
        end
    end

    assign rd_addr_a = (state_reg == ccw_pkg::S_READ) ? amount_reg : i_reg;
    assign rd_addr_b = i_reg - coin_reg;

    assign fwd_a_next = wr_en && (wr_addr == rd_addr_a);
    assign fwd_b_next = wr_en && (wr_addr == rd_addr_b);

    // Sequencer: clear, one pass per usable coin, then read the result
    always_comb
    begin
        state_next          = state_reg;
        amount_next         = amount_reg;
        i_next              = i_reg;
        coin_next           = coin_reg;
        k_next              = k_reg;
        p_vld_next          = 1'b0;
        p_addr_next         = i_reg;
        out_valid_next      = out_accept ? 1'b0 : out_valid_reg;
        way_count_next      = way_count_reg;
        count_overflow_next = count_overflow_reg;
        case (state_reg)
            ccw_pkg::S_IDLE:
            begin
                // Take a request only while idle
                if (in_accept)
                begin
                    amount_next = (amt_ext > CW'(MAX_AMOUNT))
                                ? AW'(MAX_AMOUNT) : AW'(amt_ext);
                    i_next      = '0;
                    state_next  = ccw_pkg::S_CLEAR;
                end
            end
            ccw_pkg::S_CLEAR:
            begin
                if (i_reg == amount_reg)
                begin
                    k_next     = '0;
                    state_next = ccw_pkg::S_SETUP;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ccw_pkg::S_SETUP:
            begin
                if (k_reg >= n_used)
                begin
                    state_next = ccw_pkg::S_READ;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    // Skip a zero coin or one larger than the amount
                    if (cur_coin != '0 && CW'(cur_coin) <= CW'(amount_reg))
                    begin
                        coin_next  = AW'(cur_coin);
                        i_next     = AW'(cur_coin);
                        state_next = ccw_pkg::S_RUN;
                    end
                end
            end
            ccw_pkg::S_RUN:
            begin
                p_vld_next = 1'b1;
                if (i_reg == amount_reg)
                begin
                    state_next = ccw_pkg::S_SETUP;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ccw_pkg::S_READ:
            begin
                // Issue the result read once the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ccw_pkg::S_WAIT;
                end
            end
            ccw_pkg::S_WAIT:
            begin
                out_valid_next      = 1'b1;
                way_count_next      = ccw_pkg::OUT_W'(word_a[COUNT_WIDTH-1:0]);
                count_overflow_next = word_a[COUNT_WIDTH];
                state_next          = ccw_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ccw_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ccw_pkg::S_IDLE;
            k_reg          <= '0;
            p_vld_reg      <= 1'b0;
            fwd_a_reg      <= 1'b0;
            fwd_b_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            coin_count_reg <= ccw_pkg::COIN_COUNT_RST;
            for (int j = 0; j < MAX_COINS; j++)
            begin
                coin_value_reg[j] <= ccw_pkg::COIN_VALUE_RST[j];
            end
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            p_vld_reg      <= p_vld_next;
            fwd_a_reg      <= fwd_a_next;
            fwd_b_reg      <= fwd_b_next;
            out_valid_reg  <= out_valid_next;
            coin_count_reg <= coin_count_next;
            for (int j = 0; j < MAX_COINS; j++)
            begin
                coin_value_reg[j] <= coin_value_next[j];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        amount_reg         <= amount_next;
        i_reg              <= i_next;
        coin_reg           <= coin_next;
        p_addr_reg         <= p_addr_next;
        fwd_data_reg       <= wr_data;
        way_count_reg      <= way_count_next;
        count_overflow_reg <= count_overflow_next;
    end

    ccw_ram #(
        .WIDTH(MW),
        .DEPTH(MAX_AMOUNT + 1)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    assign in_stall       = (state_reg != ccw_pkg::S_IDLE);
    assign out_valid      = out_valid_reg;
    assign way_count      = way_count_reg;
    assign count_overflow = count_overflow_reg;
    assign cfg_ready      = 1'b1;

endmodule

`default_nettype wire

// ----- src/ccw_checker.sv -----
// Port-level checker of the coin change way counter, bound to the top level.
// Depends on ccw_pkg and coin_change_way_counter_defines.svh.
`include "coin_change_way_counter_defines.svh"
`default_nettype none

module ccw_checker #(
    parameter int COUNT_WIDTH = ccw_pkg::COUNT_WIDTH_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [ccw_pkg::OUT_W-1:0]     way_count,
    input wire logic                          count_overflow
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [ccw_pkg::OUT_W-1:0] SAT_VALUE = ccw_pkg::OUT_W'(CNT_MAX);

    // A taken request keeps the block busy and gives no result at once
    `CCW_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall && !$rose(out_valid), "request did not start a computation")

    // An overflowed count is reported as the saturated value
    `CCW_ASSERT_NOW(a_overflow_saturates, clk, rst_n, out_valid && count_overflow, way_count == SAT_VALUE, "overflow flag without saturated count")

    // Hold a stalled result
    `CCW_ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_valid && out_stall, out_valid && $stable(way_count) && $stable(count_overflow), "stalled result changed")

    // Drop a result only after it was taken
    `CCW_ASSERT_NOW(a_drop_after_take, clk, rst_n, $fell(out_valid), $past(!out_stall), "result dropped without being taken")

endmodule

bind coin_change_way_counter ccw_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
) u_ccw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .way_count      (way_count),
    .count_overflow (count_overflow)
);

`default_nettype wire
